// ----- rtl/gftu_pkg.sv -----
// Package for the twelve-uniform Gaussian generator.
// Holds the shared types, the back-end state encoding and the Q30 coefficients.
// No dependencies.
`default_nettype none

package gftu_pkg;

    // Number of uniform samples summed for one result.
    localparam int unsigned GROUP_SIZE = 12;
    localparam int unsigned CNT_W      = 4;

    // Result width: signed Q5.16.
    localparam int unsigned OUT_W = 22;

    // Depth of the queue between front and back end.
    localparam int unsigned Q_DEPTH = 2;

    // Fixed-point helpers for the coefficient table.
    localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
    localparam logic [63:0] NANO     = 64'd1000000000;
    localparam logic [63:0] HALF_NANO = 64'd500000000;

    // Correcting polynomial coefficients, unsigned Q3.30, rounded to nearest.
    localparam logic [32:0] COEF_A1 = 33'((64'd3949846138 * Q30_ONE + HALF_NANO) / NANO);
    localparam logic [32:0] COEF_A3 = 33'((64'd252408784 * Q30_ONE + HALF_NANO) / NANO);
    localparam logic [32:0] COEF_A5 = 33'((64'd76542912 * Q30_ONE + HALF_NANO) / NANO);
    localparam logic [32:0] COEF_A7 = 33'((64'd8355968 * Q30_ONE + HALF_NANO) / NANO);
    localparam logic [32:0] COEF_A9 = 33'((64'd29899776 * Q30_ONE + HALF_NANO) / NANO);

    // Status of the sum queue as seen by its neighbors.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        B_IDLE,
        B_SQ_LO,
        B_SQ_HI,
        B_HO_LO,
        B_HO_HI,
        B_FIN_LO,
        B_FIN_HI
    } back_state_t;

    // Coefficient added after each Horner step, highest order first.
    function automatic logic [32:0] horner_coef(input logic [1:0] step);
        logic [32:0] c;
        case (step)
            2'd0:    c = COEF_A7;
            2'd1:    c = COEF_A5;
            2'd2:    c = COEF_A3;
            2'd3:    c = COEF_A1;
            default: c = COEF_A1;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/gaussian_from_twelve_uniforms_core.sv -----
// Gaussian generator from twelve uniform samples: a summing front end, a sum
// queue and a polynomial back end, each stalling on its own. The front end
// takes one uniform sample per cycle while full is low and turns every twelfth
// into a result: the sum of the group, less six and divided by four, is passed
// through the odd polynomial a1 r + a3 r^3 + ... + a9 r^9 by Horner's rule in
// r^2. The back end runs the six products through one shared 33x16 multiplier,
// each as a low half and then a high half; a two-entry sum queue lets
// back-to-back groups flow at one sample per cycle while results are popped. A
// result is registered on normal_value, signed Q5.16, and held until popped.
// Depends on gftu_pkg, gftu_front, gftu_fifo and gftu_back.
`default_nettype none

module gaussian_from_twelve_uniforms_core #(
    parameter int unsigned UNIFORM_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic [UNIFORM_BITS-1:0]              uniform_sample,
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic signed [gftu_pkg::OUT_W-1:0]         normal_value
);

    localparam int unsigned SUM_W = UNIFORM_BITS + 4;

    gftu_pkg::fifo_stat_t q_stat;
    logic                 q_push;
    logic                 q_pop;
    logic [SUM_W-1:0]     q_wr_data;
    logic [SUM_W-1:0]     q_rd_data;

    // Sample accumulation.
    gftu_front #(
        .UNIFORM_BITS (UNIFORM_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .uniform_sample (uniform_sample),
        .full           (full),
        .q_stat         (q_stat),
        .q_push         (q_push),
        .q_data         (q_wr_data)
    );

    // Queue of finished group sums.
    gftu_fifo #(
        .WIDTH (SUM_W)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    // Polynomial evaluation and result slot.
    gftu_back #(
        .UNIFORM_BITS (UNIFORM_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .q_data       (q_rd_data),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .normal_value (normal_value)
    );

endmodule

`default_nettype wire

// ----- rtl/gftu_fifo.sv -----
// Two-entry queue that carries finished group sums from front to back end.
// Depends on gftu_pkg for the status struct and the depth.
`default_nettype none

module gftu_fifo #(
    parameter int unsigned WIDTH = 20
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic                 pop,
    output logic [WIDTH-1:0]          rd_data,
    output gftu_pkg::fifo_stat_t      stat
);

    localparam int unsigned PTR_W = $clog2(gftu_pkg::Q_DEPTH);
    localparam int unsigned CNT_W = $clog2(gftu_pkg::Q_DEPTH + 1);

    logic [WIDTH-1:0] mem [gftu_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign stat.full  = (cnt_reg == CNT_W'(gftu_pkg::Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_data    = mem[rd_ptr_reg];

    // Storage is written only; no reset needed on the payload.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // The occupancy never exceeds the depth.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(gftu_pkg::Q_DEPTH))
        else $error("queue occupancy above depth");

    // Pointers stay apart by exactly the occupancy.
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == PTR_W'(cnt_reg))
        else $error("queue pointers disagree with occupancy");

    // A push into a full queue would lose a sum.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("push into full queue");

endmodule

`default_nettype wire

// ----- rtl/gftu_front.sv -----
// Front end: accepts uniform samples and sums them in groups of twelve.
// Depends on gftu_pkg; hands each finished sum to the queue.
`default_nettype none

module gftu_front #(
    parameter int unsigned UNIFORM_BITS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire logic [UNIFORM_BITS-1:0]  uniform_sample,
    output logic                          full,
    input  wire gftu_pkg::fifo_stat_t     q_stat,
    output logic                          q_push,
    output logic [UNIFORM_BITS+3:0]       q_data
);

    localparam int unsigned SUM_W = UNIFORM_BITS + 4;
    localparam int unsigned CNT_W = gftu_pkg::CNT_W;

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             last;
    logic             accept;
    logic [SUM_W-1:0] sum_total;

    // The last sample of a group needs room in the queue.
    assign last      = (count_reg == CNT_W'(gftu_pkg::GROUP_SIZE - 1));
    assign full      = last && q_stat.full;
    assign accept    = push && !full;
    assign sum_total = sum_reg + SUM_W'(uniform_sample);
    assign q_push    = accept && last;
    assign q_data    = sum_total;

    // Group accumulation and sample count.
    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (last)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = sum_total;
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    // The count stays inside one group.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(gftu_pkg::GROUP_SIZE))
        else $error("sample count left its group");

    // A finished group always restarts from an empty sum.
    a_group_restart: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> (count_reg == '0) && (sum_reg == '0))
        else $error("group did not restart after hand-off");

    // The sum can only be nonzero once samples have been taken.
    a_sum_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (sum_reg == '0))
        else $error("stale sum at start of group");

endmodule

`default_nettype wire

// ----- rtl/gftu_back.sv -----
// Back end: turns each group sum into a corrected normal value.
// Depends on gftu_pkg; one shared 33x16 multiplier, each product as a low and a high half.
`default_nettype none

module gftu_back #(
    parameter int unsigned UNIFORM_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gftu_pkg::fifo_stat_t          q_stat,
    input  wire logic [UNIFORM_BITS+3:0]       q_data,
    output logic                               q_pop,
    input  wire logic                          pop,
    output logic                               empty,
    output logic signed [gftu_pkg::OUT_W-1:0]  normal_value
);

    localparam int unsigned SUM_W  = UNIFORM_BITS + 4;
    localparam int unsigned OUT_W  = gftu_pkg::OUT_W;
    localparam logic [31:0] CENTRE = 32'd6 << 28;

    gftu_pkg::back_state_t state_reg;
    gftu_pkg::back_state_t state_next;

    logic              neg_reg;
    logic              neg_next;
    logic [30:0]       mag_reg;
    logic [30:0]       mag_next;
    logic [31:0]       r2_reg;
    logic [31:0]       r2_next;
    logic [32:0]       acc_reg;
    logic [32:0]       acc_next;
    logic [48:0]       plo_reg;
    logic [48:0]       plo_next;
    logic [1:0]        step_reg;
    logic [1:0]        step_next;
    logic [OUT_W-1:0]  result_reg;
    logic [OUT_W-1:0]  result_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic [31:0]       s28;
    logic              load_neg;
    logic [30:0]       load_mag;
    logic [32:0]       mul_a;
    logic [31:0]       mul_b;
    logic [15:0]       mul_half;
    logic [48:0]       part;
    logic [64:0]       prod;
    logic [34:0]       prod_q30;
    logic [64:0]       fin_round;
    logic [19:0]       fin_mag;
    logic              out_pop;
    logic              slot_free;

    // Bring the group sum to unsigned Q4.28.
    if (UNIFORM_BITS <= 28)
    begin : g_sum_up
        assign s28 = 32'(q_data) << (28 - UNIFORM_BITS);
    end
    else
    begin : g_sum_down
        localparam int unsigned SH = UNIFORM_BITS - 28;
        logic [SUM_W:0] sum_rnd;
        assign sum_rnd = {1'b0, q_data} + ((SUM_W + 1)'(1) << (SH - 1));
        assign s28     = 32'(sum_rnd >> SH);
    end

    // Sign and magnitude of r in Q30.
    assign load_neg = (s28 < CENTRE);
    assign load_mag = load_neg ? 31'(CENTRE - s28) : 31'(s28 - CENTRE);

    // Shared multiplier operands: square uses |r| twice, Horner uses acc*r^2,
    // the final step uses acc*|r|.
    always_comb
    begin
        case (state_reg)
            gftu_pkg::B_SQ_LO,
            gftu_pkg::B_SQ_HI:
            begin
                mul_a = {2'b00, mag_reg};
                mul_b = {1'b0, mag_reg};
            end
            gftu_pkg::B_HO_LO,
            gftu_pkg::B_HO_HI:
            begin
                mul_a = acc_reg;
                mul_b = r2_reg;
            end
            default:
            begin
                mul_a = acc_reg;
                mul_b = {1'b0, mag_reg};
            end
        endcase
    end

    // Low half in the LO state, high half added in the HI state.
    assign mul_half  = (state_reg == gftu_pkg::B_SQ_HI || state_reg == gftu_pkg::B_HO_HI ||
                        state_reg == gftu_pkg::B_FIN_HI) ? mul_b[31:16] : mul_b[15:0];
    assign part      = 49'(mul_a) * 49'(mul_half);
    assign prod      = 65'(plo_reg) + (65'(part) << 16);
    assign prod_q30  = 35'((prod + (65'd1 << 29)) >> 30);
    assign fin_round = prod + (65'd1 << 43);
    assign fin_mag   = fin_round[63:44];

    assign empty        = !out_valid_reg;
    assign normal_value = result_reg;
    assign out_pop      = pop && out_valid_reg;
    assign slot_free    = !out_valid_reg || out_pop;

    // Sequencer and datapath updates.
    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        r2_next        = r2_reg;
        acc_next       = acc_reg;
        plo_next       = plo_reg;
        step_next      = step_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !out_pop;
        q_pop          = 1'b0;
        case (state_reg)
            gftu_pkg::B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop      = 1'b1;
                    neg_next   = load_neg;
                    mag_next   = load_mag;
                    state_next = gftu_pkg::B_SQ_LO;
                end
            end
            gftu_pkg::B_SQ_LO,
            gftu_pkg::B_HO_LO,
            gftu_pkg::B_FIN_LO:
            begin
                plo_next = part;
                case (state_reg)
                    gftu_pkg::B_SQ_LO: state_next = gftu_pkg::B_SQ_HI;
                    gftu_pkg::B_HO_LO: state_next = gftu_pkg::B_HO_HI;
                    default:           state_next = gftu_pkg::B_FIN_HI;
                endcase
            end
            gftu_pkg::B_SQ_HI:
            begin
                r2_next    = prod_q30[31:0];
                acc_next   = gftu_pkg::COEF_A9;
                step_next  = '0;
                state_next = gftu_pkg::B_HO_LO;
            end
            gftu_pkg::B_HO_HI:
            begin
                acc_next  = prod_q30[32:0] + gftu_pkg::horner_coef(step_reg);
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    state_next = gftu_pkg::B_FIN_LO;
                end
                else
                begin
                    state_next = gftu_pkg::B_HO_LO;
                end
            end
            gftu_pkg::B_FIN_HI:
            begin
                // Wait here until the result slot is free.
                if (slot_free)
                begin
                    result_next    = neg_reg ? (OUT_W'(0) - OUT_W'(fin_mag))
                                             : OUT_W'(fin_mag);
                    out_valid_next = 1'b1;
                    // Start the next sum at once when one is waiting.
                    if (!q_stat.empty)
                    begin
                        q_pop      = 1'b1;
                        neg_next   = load_neg;
                        mag_next   = load_mag;
                        state_next = gftu_pkg::B_SQ_LO;
                    end
                    else
                    begin
                        state_next = gftu_pkg::B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = gftu_pkg::B_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gftu_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        r2_reg     <= r2_next;
        acc_reg    <= acc_next;
        plo_reg    <= plo_next;
        result_reg <= result_next;
    end

    // A new result appears only at the end of the final product.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == gftu_pkg::B_FIN_HI))
        else $error("result appeared outside the final step");

    // A waiting result is never overwritten before it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> $stable(result_reg))
        else $error("waiting result changed");

    // Sums leave the queue only when the sequencer is ready to start one.
    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty && (state_reg == gftu_pkg::B_IDLE ||
                                    state_reg == gftu_pkg::B_FIN_HI))
        else $error("queue popped at wrong time");

    // The Horner accumulator stays below six in Q30.
    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gftu_pkg::B_HO_LO || state_reg == gftu_pkg::B_FIN_LO)
            |-> (acc_reg < (33'd6 << 30)))
        else $error("accumulator out of range");

endmodule

`default_nettype wire
